[rtl/piecewise_contrast_map_defines.svh]
// Assertion macros shared by the contrast map RTL.
`ifndef PIECEWISE_CONTRAST_MAP_DEFINES_SVH
`define PIECEWISE_CONTRAST_MAP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define PCM_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("pcm check failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define PCM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("pcm check failed: next-cycle implication");

`else

`define PCM_ASSERT_NOW(label, clk, rst, cond, prop)
`define PCM_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

[rtl/pcm_pkg.sv]
// Types, register codes and per-stage functions of the contrast map.
package pcm_pkg;

   localparam int NUM_LANES     = 3;
   localparam int DIV_STAGES    = 4;   // two quotient bits per stage
   localparam logic [7:0] LEVEL_MAX = 8'd255;

   // register indexes of the configuration port
   localparam logic [2:0] CSR_MODE      = 3'd0;
   localparam logic [2:0] CSR_KNEE1_IN  = 3'd1;
   localparam logic [2:0] CSR_KNEE1_OUT = 3'd2;
   localparam logic [2:0] CSR_KNEE2_IN  = 3'd3;
   localparam logic [2:0] CSR_KNEE2_OUT = 3'd4;
   localparam logic [2:0] CSR_KNEE3_IN  = 3'd5;
   localparam logic [2:0] CSR_KNEE3_OUT = 3'd6;

   localparam logic       MODE_PIECEWISE = 1'b0;
   localparam logic       MODE_STRETCH   = 1'b1;

   localparam logic [7:0] RST_KNEE1 = 8'd64;
   localparam logic [7:0] RST_KNEE2 = 8'd128;
   localparam logic [7:0] RST_KNEE3 = 8'd192;

   typedef struct packed {
      logic       mode;
      logic [7:0] k1i;
      logic [7:0] k1o;
      logic [7:0] k2i;
      logic [7:0] k2o;
      logic [7:0] k3i;
      logic [7:0] k3o;
   } cfg_type;

   // segment picked for one channel: offset, slope terms and start level
   typedef struct packed {
      logic [7:0] dx;
      logic [7:0] dy_mag;
      logic       dy_neg;
      logic [7:0] wid;
      logic [7:0] y0;
   } seg_type;

   // running division of |dx*dy| by the segment width
   typedef struct packed {
      logic [15:0] rem;
      logic [7:0]  quo;
      logic [7:0]  wid;
      logic        neg;
      logic [7:0]  y0;
   } div_type;

   function automatic seg_type seg_build(logic [7:0] v, logic [7:0] x0, logic [7:0] y0,
                                         logic [7:0] x1, logic [7:0] y1);
      seg_type          s;
      logic signed [8:0] dy;
      logic [7:0]       w;
      dy       = $signed({1'b0, y1}) - $signed({1'b0, y0});
      w        = x1 - x0;
      s.dx     = v - x0;
      s.dy_neg = dy[8];
      s.dy_mag = dy[8] ? 8'(-dy) : dy[7:0];
      // a zero-width segment only holds v == x0, so dx is zero; keep the divisor nonzero
      s.wid    = (w == 8'd0) ? 8'd1 : w;
      s.y0     = y0;
      return s;
   endfunction

   function automatic seg_type seg_select(cfg_type c, logic [7:0] v);
      seg_type s;
      s = seg_build(v, 8'd0, 8'd0, 8'd0, 8'd0);
      if (c.mode == MODE_PIECEWISE) begin
         if (v <= c.k1i) begin
            s = seg_build(v, 8'd0, 8'd0, c.k1i, c.k1o);
         end else if (v <= c.k2i) begin
            s = seg_build(v, c.k1i, c.k1o, c.k2i, c.k2o);
         end else if (v <= c.k3i) begin
            s = seg_build(v, c.k2i, c.k2o, c.k3i, c.k3o);
         end else begin
            s = seg_build(v, c.k3i, c.k3o, LEVEL_MAX, LEVEL_MAX);
         end
      end else begin
         if (v <= c.k1i) begin
            s = seg_build(v, v, 8'd0, v, 8'd0);
         end else if (v <= c.k2i) begin
            s = seg_build(v, c.k1i, 8'd0, c.k2i, LEVEL_MAX);
         end else begin
            s = seg_build(v, v, LEVEL_MAX, v, LEVEL_MAX);
         end
      end
      return s;
   endfunction

   // one restoring step: quotient bit pos (quotient is known to fit 8 bits)
   function automatic div_type div_bit(div_type d, logic [2:0] pos);
      div_type     r;
      logic [15:0] sub;
      r   = d;
      sub = {8'd0, d.wid} << pos;
      if (d.rem >= sub) begin
         r.rem = d.rem - sub;
         r.quo = d.quo | (8'd1 << pos);
      end
      return r;
   endfunction

   function automatic logic [7:0] level_out(div_type d);
      logic signed [9:0] q;
      logic signed [9:0] res;
      q   = $signed({2'b00, d.quo});
      res = $signed({2'b00, d.y0}) + (d.neg ? -q : q);
      if (res < 10'sd0) begin
         return 8'd0;
      end else if (res > $signed({2'b00, LEVEL_MAX})) begin
         return LEVEL_MAX;
      end
      return res[7:0];
   endfunction

endpackage

[rtl/piecewise_contrast_map.sv]
// Piecewise contrast map: per-channel contrast curve for one RGB pixel word.
// Pipeline from an accepted req word to rsp_valid: segment pick, multiply,
// four two-bit divide stages, output register. Throughput: one word per cycle while rsp_stall is low.
// Every stage carries its own valid bit and fills bubbles, so stalls lose nothing.
// Reset: synchronous, clears all valid bits and loads the default curve
// (identity knees at 64/128/192, piecewise mode).
module piecewise_contrast_map
   import pcm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input words
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_chan_a,
   input  logic [7:0] req_chan_b,
   input  logic [7:0] req_chan_c,
   // result words
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_mapped_a,
   output logic [7:0] rsp_mapped_b,
   output logic [7:0] rsp_mapped_c,
   // register writes
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wr_data
);

`include "piecewise_contrast_map_defines.svh"

   // ---------------------------------------------------------------------------
   // Configuration registers. Write them only while the pipe is empty; the block itself does not enforce it.
   // ---------------------------------------------------------------------------
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:      cfg_in.mode = csr_wr_data[0];
            CSR_KNEE1_IN:  cfg_in.k1i  = csr_wr_data;
            CSR_KNEE1_OUT: cfg_in.k1o  = csr_wr_data;
            CSR_KNEE2_IN:  cfg_in.k2i  = csr_wr_data;
            CSR_KNEE2_OUT: cfg_in.k2o  = csr_wr_data;
            CSR_KNEE3_IN:  cfg_in.k3i  = csr_wr_data;
            CSR_KNEE3_OUT: cfg_in.k3o  = csr_wr_data;
            default:       cfg_in      = cfg_ff;   // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: MODE_PIECEWISE,
                     k1i: RST_KNEE1, k1o: RST_KNEE1,
                     k2i: RST_KNEE2, k2o: RST_KNEE2,
                     k3i: RST_KNEE3, k3o: RST_KNEE3};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline registers. Stage 0 holds the picked segment, div stage 0 the
   // product |dx*dy|, div stages 1..4 resolve two quotient bits each, and the
   // rsp registers hold the finished levels.
   // ---------------------------------------------------------------------------
   logic    seg_vld_ff;
   seg_type seg_ff [NUM_LANES];
   logic    div_vld_ff [DIV_STAGES+1];
   div_type div_ff [DIV_STAGES+1][NUM_LANES];
   logic    rsp_vld_ff;
   logic [7:0] rsp_lvl_ff [NUM_LANES];

   logic [7:0] req_lvl [NUM_LANES];
   assign req_lvl[0] = req_chan_a;
   assign req_lvl[1] = req_chan_b;
   assign req_lvl[2] = req_chan_c;

   // A stage may load when it is empty or its occupant moves on this cycle.
   logic out_rdy;
   logic div_rdy [DIV_STAGES+1];
   logic seg_rdy;

   always_comb begin
      out_rdy = !rsp_vld_ff || !rsp_stall;
      div_rdy[DIV_STAGES] = !div_vld_ff[DIV_STAGES] || out_rdy;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         div_rdy[k] = !div_vld_ff[k] || div_rdy[k+1];
      end
      seg_rdy = !seg_vld_ff || div_rdy[0];
   end

   assign req_stall = !seg_rdy;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_vld_ff <= 1'b0;
         for (int k = 0; k <= DIV_STAGES; k++) begin
            div_vld_ff[k] <= 1'b0;
         end
         rsp_vld_ff <= 1'b0;
      end else begin
         if (seg_rdy) begin
            seg_vld_ff <= req_valid;
         end
         if (div_rdy[0]) begin
            div_vld_ff[0] <= seg_vld_ff;
         end
         for (int k = 1; k <= DIV_STAGES; k++) begin
            if (div_rdy[k]) begin
               div_vld_ff[k] <= div_vld_ff[k-1];
            end
         end
         if (out_rdy) begin
            rsp_vld_ff <= div_vld_ff[DIV_STAGES];
         end
      end
   end

   // payload: advance on the same enables, no reset needed
   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_LANES; l++) begin
         // pick the segment the level falls in
         if (seg_rdy) begin
            seg_ff[l] <= seg_select(cfg_ff, req_lvl[l]);
         end
         // form |dx*dy|, one 8x8 multiply per lane
         if (div_rdy[0]) begin
            div_ff[0][l].rem <= {8'd0, seg_ff[l].dx} * {8'd0, seg_ff[l].dy_mag};
            div_ff[0][l].quo <= 8'd0;
            div_ff[0][l].wid <= seg_ff[l].wid;
            div_ff[0][l].neg <= seg_ff[l].dy_neg;
            div_ff[0][l].y0  <= seg_ff[l].y0;
         end
         // divide by the segment width, high quotient bits first
         for (int k = 1; k <= DIV_STAGES; k++) begin
            if (div_rdy[k]) begin
               div_ff[k][l] <= div_bit(div_bit(div_ff[k-1][l], 3'(9 - 2 * k)),
                                       3'(8 - 2 * k));
            end
         end
         // apply the slope sign, add the start level, saturate
         if (out_rdy) begin
            rsp_lvl_ff[l] <= level_out(div_ff[DIV_STAGES][l]);
         end
      end
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_mapped_a = rsp_lvl_ff[0];
   assign rsp_mapped_b = rsp_lvl_ff[1];
   assign rsp_mapped_c = rsp_lvl_ff[2];

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   // a draining output never blocks the input
   `PCM_ASSERT_NOW(a_no_false_stall, clock, reset, !rsp_stall, !req_stall)

   // a blocked last divide stage keeps its valid bit and its lane 0 payload
   `PCM_ASSERT_NEXT(a_div_hold, clock, reset, div_vld_ff[DIV_STAGES] && !out_rdy, div_vld_ff[DIV_STAGES] && $stable(div_ff[DIV_STAGES][0]))

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane_chk
      // the picked segment never divides by zero
      `PCM_ASSERT_NOW(a_wid_nonzero, clock, reset, seg_vld_ff, seg_ff[l].wid != 8'd0)

      // the finished division leaves a remainder below the divisor
      `PCM_ASSERT_NOW(a_rem_below, clock, reset, div_vld_ff[DIV_STAGES], div_ff[DIV_STAGES][l].rem < {8'd0, div_ff[DIV_STAGES][l].wid})
   end

endmodule
